// ----- rtl/core/keyed_tile_cache_lru_top_macros.svh -----
// Assertion macros for the keyed tile cache.
`ifndef KEYED_TILE_CACHE_LRU_TOP_MACROS_SVH
`define KEYED_TILE_CACHE_LRU_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KTC_ASSERT_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("ktc assertion failed");
`define KTC_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("ktc assertion failed");
`else
`define KTC_ASSERT_IMPL(lbl, a, c)
`define KTC_ASSERT_NEXT(lbl, a, c)
`endif
`endif

// ----- rtl/core/ktc_pkg.sv -----
// Shared constants and types of the keyed tile cache.
package ktc_pkg;
	localparam int ENTRIES = 64;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CAP_W = 7;
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int KEY_W = 53;
	localparam int HND_W = 16;
	localparam int STAMP_W = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd40;
	localparam logic FN_LOOKUP = 1'b0;
	localparam logic FN_FILL = 1'b1;

	// running record handed from cell to cell during a sweep
	typedef struct packed {
		logic found;
		logic [IDX_W-1:0] found_idx;
		logic [HND_W-1:0] found_handle;
		logic have_old;
		logic [IDX_W-1:0] old_idx;
		logic [STAMP_W-1:0] best_age;
		logic [HND_W-1:0] old_handle;
		logic [CNT_W-1:0] used;
		logic have_free;
		logic [IDX_W-1:0] free_idx;
	} rec_t;

	// update command broadcast to all cells
	typedef struct packed {
		logic clr_en;
		logic [IDX_W-1:0] clr_idx;
		logic wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic wr_new;
		logic wr_handle;
		logic [KEY_W-1:0] key;
		logic [HND_W-1:0] handle;
		logic [STAMP_W-1:0] stamp;
	} cmd_t;
endpackage

// ----- rtl/core/ktc_cell.sv -----
// One cache entry cell: holds an entry and folds it into the passing sweep record.
module ktc_cell (
	input logic clk,
	input logic arst_n,
	input logic [ktc_pkg::IDX_W-1:0] idx,
	input logic step_in,
	input ktc_pkg::rec_t rec_in,
	input logic [ktc_pkg::KEY_W-1:0] key,
	input logic [ktc_pkg::STAMP_W-1:0] now,
	input ktc_pkg::cmd_t cmd,
	output logic step_out,
	output ktc_pkg::rec_t rec_out
);
	logic valid_q;
	logic [ktc_pkg::KEY_W-1:0] key_q;
	logic [ktc_pkg::HND_W-1:0] handle_q;
	logic [ktc_pkg::STAMP_W-1:0] stamp_q;
	logic [ktc_pkg::STAMP_W-1:0] age;
	logic match;
	ktc_pkg::rec_t rec_nx;
	logic step_q;
	ktc_pkg::rec_t rec_q;

	assign age = now - stamp_q;
	assign match = valid_q && (key_q == key);

	// fold this entry into the record
	always_comb begin
		rec_nx = rec_in;
		if (match && !rec_in.found) begin
			rec_nx.found = 1'b1;
			rec_nx.found_idx = idx;
			rec_nx.found_handle = handle_q;
		end
		rec_nx.used = rec_in.used + ktc_pkg::CNT_W'(valid_q);
		if (valid_q && (!rec_in.have_old || age > rec_in.best_age)) begin
			rec_nx.have_old = 1'b1;
			rec_nx.old_idx = idx;
			rec_nx.best_age = age;
			rec_nx.old_handle = handle_q;
		end
		if (!valid_q && !rec_in.have_free) begin
			rec_nx.have_free = 1'b1;
			rec_nx.free_idx = idx;
		end
	end

	// advance the sweep token, hold the record between sweeps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 1'b0;
		end else begin
			step_q <= step_in;
		end
	end

	always_ff @(posedge clk) begin
		if (step_in) begin
			rec_q <= rec_nx;
		end
	end

	// apply clear and write commands; a write wins over a clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (cmd.clr_en && cmd.clr_idx == idx) begin
				valid_q <= 1'b0;
			end
			if (cmd.wr_en && cmd.wr_idx == idx && cmd.wr_new) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && cmd.wr_idx == idx) begin
			stamp_q <= cmd.stamp;
			if (cmd.wr_new) begin
				key_q <= cmd.key;
			end
			if (cmd.wr_handle) begin
				handle_q <= cmd.handle;
			end
		end
	end

	assign step_out = step_q;
	assign rec_out = rec_q;
endmodule

// ----- rtl/core/keyed_tile_cache_lru_top.sv -----
// Items are taken one at a time: in_stall holds off a new transfer until the current
// item has finished its update; a sweep token walks the cell chain,
// one cell per cycle, gathering key match, oldest stamp, occupancy and free slot.
// A waiting result does not block the next transfer until its update cycle.
// Reset clears all valid bits, the access clock and both counters at once;
// capacity resets to 40.
`include "keyed_tile_cache_lru_top_macros.svh"
module keyed_tile_cache_lru_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic func,
	input logic [7:0] source_id,
	input logic [19:0] grid_x,
	input logic [19:0] grid_y,
	input logic [4:0] zoom,
	input logic [15:0] tile_handle,
	output logic out_valid,
	input logic out_stall,
	output logic hit,
	output logic [15:0] out_handle,
	output logic evicted,
	output logic [15:0] evicted_handle,
	output logic [31:0] hit_total,
	output logic [31:0] miss_total,
	input logic cfg_we,
	input logic [6:0] cfg_wdata
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SWEEP = 3'b010,
		ST_UPD = 3'b100
	} state_t;

	state_t state_q;
	logic go_q;
	logic func_q;
	logic [ktc_pkg::KEY_W-1:0] key_q;
	logic [ktc_pkg::HND_W-1:0] handle_q;
	logic [ktc_pkg::CAP_W-1:0] capacity_q;
	logic [ktc_pkg::STAMP_W-1:0] clock_q;
	logic [31:0] hit_q;
	logic [31:0] miss_q;
	logic out_valid_q;
	logic hit_o_q;
	logic [15:0] out_handle_q;
	logic evicted_q;
	logic [15:0] evicted_handle_q;

	logic step [ktc_pkg::ENTRIES+1];
	ktc_pkg::rec_t rec [ktc_pkg::ENTRIES+1];
	ktc_pkg::rec_t fin;
	ktc_pkg::cmd_t cmd;
	logic in_fire;
	logic upd_fire;
	logic [ktc_pkg::CMP_W-1:0] cap_eff;
	logic [ktc_pkg::CMP_W-1:0] cap_x;
	logic full;
	logic do_evict;
	logic [ktc_pkg::IDX_W-1:0] slot;
	logic stamp_use;
	logic hit_nx;
	logic miss_nx;

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire = in_valid && !in_stall;
	assign upd_fire = (state_q == ST_UPD) && (!out_valid_q || !out_stall);

	// chain of entry cells
	assign step[0] = go_q;
	assign rec[0] = '0;
	for (genvar g = 0; g < ktc_pkg::ENTRIES; g++) begin : g_cell
		ktc_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.idx(ktc_pkg::IDX_W'(g)),
			.step_in(step[g]),
			.rec_in(rec[g]),
			.key(key_q),
			.now(clock_q),
			.cmd(cmd),
			.step_out(step[g+1]),
			.rec_out(rec[g+1])
		);
	end
	assign fin = rec[ktc_pkg::ENTRIES];

	// clamp capacity to 1..ENTRIES
	always_comb begin
		cap_x = ktc_pkg::CMP_W'(capacity_q);
		cap_eff = cap_x;
		if (cap_x == '0) begin
			cap_eff = ktc_pkg::CMP_W'(1);
		end else if (cap_x > ktc_pkg::CMP_W'(ktc_pkg::ENTRIES)) begin
			cap_eff = ktc_pkg::CMP_W'(ktc_pkg::ENTRIES);
		end
	end
	assign full = ktc_pkg::CMP_W'(fin.used) >= cap_eff;

	// build the update command from the finished sweep
	always_comb begin
		do_evict = 1'b0;
		slot = fin.free_idx;
		stamp_use = 1'b0;
		hit_nx = 1'b0;
		miss_nx = 1'b0;
		cmd = '0;
		cmd.key = key_q;
		cmd.handle = handle_q;
		cmd.stamp = clock_q;
		if (func_q == ktc_pkg::FN_LOOKUP) begin
			if (fin.found) begin
				hit_nx = 1'b1;
				stamp_use = 1'b1;
				cmd.wr_en = 1'b1;
				cmd.wr_idx = fin.found_idx;
			end else begin
				miss_nx = 1'b1;
			end
		end else if (fin.found) begin
			stamp_use = 1'b1;
			cmd.wr_en = 1'b1;
			cmd.wr_idx = fin.found_idx;
			cmd.wr_handle = 1'b1;
		end else begin
			do_evict = full && fin.have_old;
			if (do_evict && !(fin.have_free && fin.free_idx < fin.old_idx)) begin
				slot = fin.old_idx;
			end
			cmd.clr_en = do_evict;
			cmd.clr_idx = fin.old_idx;
			stamp_use = do_evict || fin.have_free;
			cmd.wr_en = stamp_use;
			cmd.wr_idx = slot;
			cmd.wr_new = 1'b1;
			cmd.wr_handle = 1'b1;
		end
		if (!upd_fire) begin
			cmd.clr_en = 1'b0;
			cmd.wr_en = 1'b0;
		end
	end

	// sequence one item: idle, sweep, update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q <= 1'b0;
			capacity_q <= ktc_pkg::CAP_RESET;
			clock_q <= '0;
			hit_q <= '0;
			miss_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			go_q <= in_fire;
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (step[ktc_pkg::ENTRIES]) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (upd_fire) begin
						state_q <= ST_IDLE;
						out_valid_q <= 1'b1;
						clock_q <= clock_q + ktc_pkg::STAMP_W'(stamp_use);
						hit_q <= hit_q + 32'(hit_nx);
						miss_q <= miss_q + 32'(miss_nx);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// capture the item and the result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q <= func;
			key_q <= {source_id, grid_x, grid_y, zoom};
			handle_q <= tile_handle;
		end
		if (upd_fire) begin
			hit_o_q <= hit_nx;
			out_handle_q <= (func_q == ktc_pkg::FN_FILL) ? handle_q :
				(hit_nx ? fin.found_handle : 16'd0);
			evicted_q <= do_evict;
			evicted_handle_q <= do_evict ? fin.old_handle : 16'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign hit = hit_o_q;
	assign out_handle = out_handle_q;
	assign evicted = evicted_q;
	assign evicted_handle = evicted_handle_q;
	assign hit_total = hit_q;
	assign miss_total = miss_q;

	`KTC_ASSERT_NEXT(a_accept_sweep, in_fire, state_q == ST_SWEEP)
	`KTC_ASSERT_NEXT(a_upd_hold, (state_q == ST_UPD) && out_valid_q && out_stall, state_q == ST_UPD)
	`KTC_ASSERT_IMPL(a_evict_not_hit, out_valid_q && evicted, !hit)
endmodule
